>>> sv/first_fit_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// first fit block allocator assertion macros
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define FFBA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// same-cycle implication
`define FFBA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define FFBA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FFBA_ASSERT(name, clk, rst_n, prop)
`define FFBA_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define FFBA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and codes of the first fit block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  localparam int OFF_W      = 16;
  localparam int REQ_W      = 14;
  localparam int ADDR_W     = 32;
  localparam int S_DATA_W   = 48;
  localparam int M_DATA_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 1'b1;

  localparam logic [OFF_W-1:0] RESET_REGION_BYTES = 16'd400;

  typedef struct packed {
    logic [OFF_W-1:0] start_off;
    logic [OFF_W-1:0] end_off;
  } entry_t;

  // token that walks the cell chain
  typedef struct packed {
    logic             tok;
    logic             hit;
    logic [OFF_W-1:0] prev;
  } scan_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/ffba_cell.sv
// ----------------------------------------------------------------------------
// ffba_cell
// one table entry plus one stage of the scan token chain
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_cell #(
  parameter int IDX        = 0,
  parameter int MAX_BLOCKS = 16,
  parameter int LEN_W      = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  op_i,
  input  wire  [LEN_W-1:0]                     len_i,
  input  wire  [ffba_pkg::OFF_W-1:0]           key_i,
  input  wire                                  key_ok_i,
  input  wire  [ffba_pkg::OFF_W-1:0]           region_bytes_i,
  input  wire  [$clog2(MAX_BLOCKS+1)-1:0]      count_i,
  input  ffba_pkg::scan_t                      scan_i,
  input  wire  [$clog2(MAX_BLOCKS)-1:0]        pos_i,
  output ffba_pkg::scan_t                      scan_o,
  output logic [$clog2(MAX_BLOCKS)-1:0]        pos_o,
  input  ffba_pkg::cmd_t                       cmd_i,
  input  wire  [$clog2(MAX_BLOCKS)-1:0]        cmd_pos_i,
  input  ffba_pkg::entry_t                     new_ent_i,
  input  ffba_pkg::entry_t                     left_i,
  input  ffba_pkg::entry_t                     right_i,
  output ffba_pkg::entry_t                     ent_o
);
  import ffba_pkg::*;

  localparam int POS_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS+1);
  localparam int SUM_W = ((LEN_W > OFF_W) ? LEN_W : OFF_W) + 1;

  entry_t           ent_q;
  scan_t            scan_q, scan_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             active;
  logic [OFF_W-1:0] lim;
  logic [SUM_W-1:0] need;
  logic             take;

  always_comb begin
    active = CNT_W'(IDX) < count_i;
    lim    = (active && ent_q.start_off < region_bytes_i) ? ent_q.start_off : region_bytes_i;
    need   = SUM_W'(scan_i.prev) + SUM_W'(len_i);
    if (op_i == OP_FREE) begin
      take = active && key_ok_i && (ent_q.start_off == key_i);
    end else begin
      take = SUM_W'(lim) > need;
    end
    scan_d = scan_i;
    pos_d  = pos_i;
    if (scan_i.tok && !scan_i.hit) begin
      if (take) begin
        scan_d.hit = 1'b1;
        pos_d      = POS_W'(IDX);
      end else if (active && ent_q.end_off > scan_i.prev) begin
        scan_d.prev = ent_q.end_off;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  // table shifts: insert moves entries up, removal moves them down
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) begin
      if (POS_W'(IDX) == cmd_pos_i) begin
        ent_q <= new_ent_i;
      end else if (POS_W'(IDX) > cmd_pos_i) begin
        ent_q <= left_i;
      end
    end else if (cmd_i.rem && POS_W'(IDX) >= cmd_pos_i) begin
      ent_q <= right_i;
    end
  end

  assign scan_o = scan_q;
  assign pos_o  = pos_q;
  assign ent_o  = ent_q;

endmodule

`default_nettype wire

>>> sv/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// request sequencer, configuration registers and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_block_allocator_macros.svh"

module ffba_ctrl #(
  parameter int MAX_BLOCKS    = 16,
  parameter int ELEMENT_BYTES = 4,
  parameter int LEN_W         = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [ffba_pkg::S_DATA_W-1:0]        s_axis_tdata,
  input  wire                                  s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [ffba_pkg::M_DATA_W-1:0]        m_axis_tdata,
  output logic [ffba_pkg::STATUS_W-1:0]        m_axis_tuser,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [ffba_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [ffba_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                 op_o,
  output logic [LEN_W-1:0]                     len_o,
  output logic [ffba_pkg::OFF_W-1:0]           key_o,
  output logic                                 key_ok_o,
  output logic [ffba_pkg::OFF_W-1:0]           region_bytes_o,
  output logic [$clog2(MAX_BLOCKS+1)-1:0]      count_o,
  output ffba_pkg::scan_t                      head_o,
  input  ffba_pkg::scan_t                      tail_i,
  input  wire  [$clog2(MAX_BLOCKS)-1:0]        tail_pos_i,
  output ffba_pkg::cmd_t                       cmd_o,
  output logic [$clog2(MAX_BLOCKS)-1:0]        cmd_pos_o,
  output ffba_pkg::entry_t                     new_ent_o
);
  import ffba_pkg::*;

  localparam int POS_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS+1);
  localparam int SUM_W = ((LEN_W > OFF_W) ? LEN_W : OFF_W) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [ADDR_W-1:0]   base_q;
  logic [OFF_W-1:0]    bytes_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                op_q;
  logic [LEN_W-1:0]    len_q;
  logic [OFF_W-1:0]    key_q;
  logic                key_ok_q;
  scan_t               head_q;
  cmd_t                cmd_q, cmd_d;
  logic [POS_W-1:0]    cmd_pos_q, cmd_pos_d;
  entry_t              new_ent_q, new_ent_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
  logic                m_valid_q;
  logic [STATUS_W-1:0] m_status_q;
  logic [ADDR_W-1:0]   m_addr_q;

  logic                in_xfer;
  logic                decide;
  logic                out_free;
  logic [ADDR_W-1:0]   key_full;
  logic [SUM_W-1:0]    need;
  logic                found;
  logic                full;
  logic                clr_fit;
  logic [OFF_W-1:0]    new_start;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign decide   = (state_q == ST_SCAN) && tail_i.tok;
  assign out_free = !m_valid_q || m_axis_tready;
  assign key_full = s_axis_tdata[REQ_W +: ADDR_W] - base_q;

  always_comb begin
    need      = SUM_W'(tail_i.prev) + SUM_W'(len_q);
    found     = tail_i.hit || (SUM_W'(bytes_q) > need);
    full      = count_q == CNT_W'(MAX_BLOCKS);
    clr_fit   = SUM_W'(bytes_q) > SUM_W'(len_q);
    new_start = found ? tail_i.prev : '0;

    count_d      = count_q;
    cmd_d        = '0;
    cmd_pos_d    = cmd_pos_q;
    new_ent_d    = new_ent_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;

    if (decide) begin
      res_status_d = STATUS_MISS;
      res_addr_d   = '0;
      new_ent_d.start_off = new_start;
      new_ent_d.end_off   = OFF_W'(SUM_W'(new_start) + SUM_W'(len_q));
      if (op_q == OP_FREE) begin
        if (tail_i.hit) begin
          cmd_d.rem    = 1'b1;
          cmd_pos_d    = tail_pos_i;
          count_d      = count_q - CNT_W'(1);
          res_status_d = STATUS_DONE;
        end
      end else if (found) begin
        // a gap fits, but only a table with room takes it
        if (!full) begin
          cmd_d.ins    = 1'b1;
          cmd_pos_d    = tail_pos_i;
          count_d      = count_q + CNT_W'(1);
          res_status_d = STATUS_DONE;
          res_addr_d   = base_q + ADDR_W'(new_start);
        end
      end else begin
        // no gap: drop the whole table and retry from offset zero
        count_d = '0;
        if (clr_fit) begin
          cmd_d.ins    = 1'b1;
          cmd_pos_d    = '0;
          count_d      = CNT_W'(1);
          res_status_d = STATUS_CLEARED;
          res_addr_d   = base_q;
        end else begin
          res_status_d = STATUS_NO_ROOM;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (tail_i.tok) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      base_q    <= '0;
      bytes_q   <= RESET_REGION_BYTES;
      count_q   <= '0;
      head_q    <= '0;
      cmd_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cmd_q       <= cmd_d;
      head_q.tok  <= in_xfer;
      head_q.hit  <= 1'b0;
      head_q.prev <= '0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_REGION_BASE:  base_q  <= cfg_data_i;
          CFG_REGION_BYTES: bytes_q <= cfg_data_i[OFF_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_pos_q    <= cmd_pos_d;
    new_ent_q    <= new_ent_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    if (in_xfer) begin
      op_q     <= s_axis_tuser;
      len_q    <= LEN_W'(32'(s_axis_tdata[REQ_W-1:0]) * ELEMENT_BYTES);
      key_q    <= key_full[OFF_W-1:0];
      key_ok_q <= key_full[ADDR_W-1:OFF_W] == '0;
    end
    if (state_q == ST_DONE && out_free) begin
      m_status_q <= res_status_q;
      m_addr_q   <= res_addr_q;
    end
  end

  assign s_axis_tready  = state_q == ST_IDLE;
  assign cfg_ready_o    = 1'b1;
  assign m_axis_tvalid  = m_valid_q;
  assign m_axis_tdata   = m_addr_q;
  assign m_axis_tuser   = m_status_q;
  assign op_o           = op_q;
  assign len_o          = len_q;
  assign key_o          = key_q;
  assign key_ok_o       = key_ok_q;
  assign region_bytes_o = bytes_q;
  assign count_o        = count_q;
  assign head_o         = head_q;
  assign cmd_o          = cmd_q;
  assign cmd_pos_o      = cmd_pos_q;
  assign new_ent_o      = new_ent_q;

  `FFBA_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(MAX_BLOCKS))
  `FFBA_ASSERT_IMPL(a_tail_in_scan, clk_i, rst_ni, tail_i.tok, state_q == ST_SCAN)
  `FFBA_ASSERT_IMPL(a_cmd_after_decide, clk_i, rst_ni, cmd_q.ins || cmd_q.rem, state_q == ST_DONE)
  `FFBA_ASSERT_NEXT(a_done_holds, clk_i, rst_ni, state_q == ST_DONE && !out_free, state_q == ST_DONE)

endmodule

`default_nettype wire

>>> sv/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first fit interval allocator over a configurable region
// ----------------------------------------------------------------------------
// Each request is carried from its input transfer to its result by a scan
// token that walks the row of MAX_BLOCKS table cells one cell per cycle; the
// next request is taken only after that scan ends, the decision is made, the
// result is handed to the output register and the input ready rises again.
// The output register holds a finished result while the next request is
// already scanning. An allocate request asks for request_count *
// ELEMENT_BYTES bytes and, if the table has room, gets the first gap
// strictly larger than that; if none fits the table is dropped and the
// request retried once. A free request removes the first entry whose start
// matches free_address - region_base. Configuration writes are taken at any
// time but must only be issued while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS    = 16,
  parameter int ELEMENT_BYTES = 4
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // request stream
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [ffba_pkg::S_DATA_W-1:0]        s_axis_tdata,  // request_count, free_address
  input  wire                                  s_axis_tuser,  // operation
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [ffba_pkg::M_DATA_W-1:0]        m_axis_tdata,  // granted_address
  output logic [ffba_pkg::STATUS_W-1:0]        m_axis_tuser,  // status
  // configuration writes
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [ffba_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [ffba_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import ffba_pkg::*;

  localparam int POS_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS+1);
  // bit width of the byte length of the largest request
  localparam int LEN_W = REQ_W + $clog2(ELEMENT_BYTES);

  // values broadcast to every cell during a scan
  logic             op;
  logic [LEN_W-1:0] len;
  logic [OFF_W-1:0] key;
  logic             key_ok;
  logic [OFF_W-1:0] region_bytes;
  logic [CNT_W-1:0] count;

  // table update broadcast
  cmd_t             cmd;
  logic [POS_W-1:0] cmd_pos;
  entry_t           new_ent;

  // token chain: link k feeds cell k, link MAX_BLOCKS is the tail
  scan_t            scan_w [MAX_BLOCKS+1];
  logic [POS_W-1:0] pos_w  [MAX_BLOCKS+1];
  entry_t           ent_w  [MAX_BLOCKS];

  assign pos_w[0] = '0;

  ffba_ctrl #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .ELEMENT_BYTES (ELEMENT_BYTES),
    .LEN_W         (LEN_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .op_o           (op),
    .len_o          (len),
    .key_o          (key),
    .key_ok_o       (key_ok),
    .region_bytes_o (region_bytes),
    .count_o        (count),
    .head_o         (scan_w[0]),
    .tail_i         (scan_w[MAX_BLOCKS]),
    .tail_pos_i     (pos_w[MAX_BLOCKS]),
    .cmd_o          (cmd),
    .cmd_pos_o      (cmd_pos),
    .new_ent_o      (new_ent)
  );

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;

    // the first cell never takes from the left, the last never from the right
    if (k == 0) begin : g_first
      assign left_ent = new_ent;
    end else begin : g_mid_left
      assign left_ent = ent_w[k-1];
    end
    if (k == MAX_BLOCKS-1) begin : g_last
      assign right_ent = ent_w[k];
    end else begin : g_mid_right
      assign right_ent = ent_w[k+1];
    end

    ffba_cell #(
      .IDX        (k),
      .MAX_BLOCKS (MAX_BLOCKS),
      .LEN_W      (LEN_W)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .op_i           (op),
      .len_i          (len),
      .key_i          (key),
      .key_ok_i       (key_ok),
      .region_bytes_i (region_bytes),
      .count_i        (count),
      .scan_i         (scan_w[k]),
      .pos_i          (pos_w[k]),
      .scan_o         (scan_w[k+1]),
      .pos_o          (pos_w[k+1]),
      .cmd_i          (cmd),
      .cmd_pos_i      (cmd_pos),
      .new_ent_i      (new_ent),
      .left_i         (left_ent),
      .right_i        (right_ent),
      .ent_o          (ent_w[k])
    );
  end

endmodule

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator testbench
// drives allocate and free requests with random idling on both streams and
// checks every result against a first fit table predictor kept in step with
// the accepted requests; the region is reprogrammed between phases
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;

  localparam int MAX_BLOCKS    = 16;
  localparam int ELEMENT_BYTES = 4;
  localparam int LONG_HOLD     = 300;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int MAX_PRINTS    = 40;

  // expected results of the accepted requests, with the table they act on
  class alloc_scoreboard;
    typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   granted;
    } grant_t;

    logic [ADDR_W-1:0] region_base;
    logic [OFF_W-1:0]  region_bytes;
    logic [OFF_W-1:0]  blk_start[MAX_BLOCKS];
    logic [OFF_W-1:0]  blk_end[MAX_BLOCKS];
    int unsigned       blk_count;
    grant_t            grant_q[$];
    int unsigned       errors, results, n_alloc, n_free, n_retry, n_no_room, n_full, n_miss;

    function new();
      region_base  = '0;
      region_bytes = RESET_REGION_BYTES;
      blk_count    = 0;
      errors       = 0;
      results      = 0;
      n_alloc      = 0;
      n_free       = 0;
      n_retry      = 0;
      n_no_room    = 0;
      n_full       = 0;
      n_miss       = 0;
    endfunction

    function int pending();
      return grant_q.size();
    endfunction

    function void set_region(logic [ADDR_W-1:0] base, logic [OFF_W-1:0] bytes);
      region_base  = base;
      region_bytes = bytes;
    endfunction

    // index of the first gap wider than len, region end as last bound
    function int first_fit(input int unsigned len, output int unsigned off);
      int unsigned prev;
      int unsigned lim;
      prev = 0;
      off  = 0;
      for (int i = 0; i <= blk_count && i <= MAX_BLOCKS; i++) begin
        lim = region_bytes;
        if (i < blk_count && blk_start[i] < lim) lim = blk_start[i];
        if (lim > prev + len) begin
          off = prev;
          return i;
        end
        if (i < blk_count && blk_end[i] > prev) prev = blk_end[i];
      end
      return -1;
    endfunction

    function void note_request(logic op, logic [REQ_W-1:0] req_count, logic [ADDR_W-1:0] addr);
      int unsigned len;
      int unsigned off;
      int          pos;
      bit          retried;
      logic [ADDR_W-1:0] rel;
      grant_t      g;
      g.status = STATUS_MISS;
      g.granted = '0;
      retried = 1'b0;
      if (op == OP_ALLOC) begin
        n_alloc++;
        len = req_count * ELEMENT_BYTES;
        pos = first_fit(len, off);
        if (pos < 0) begin
          blk_count = 0;
          retried = 1'b1;
          pos = first_fit(len, off);
        end
        if (pos < 0) begin
          g.status = STATUS_NO_ROOM;
          n_no_room++;
        end else if (blk_count >= MAX_BLOCKS) begin
          n_full++;
        end else begin
          for (int k = int'(blk_count); k > pos; k--) begin
            blk_start[k] = blk_start[k-1];
            blk_end[k]   = blk_end[k-1];
          end
          blk_start[pos] = OFF_W'(off);
          blk_end[pos]   = OFF_W'(off + len);
          blk_count++;
          g.status  = retried ? STATUS_CLEARED : STATUS_DONE;
          g.granted = region_base + off;
          if (retried) n_retry++;
        end
      end else begin
        n_free++;
        rel = addr - region_base;
        for (int i = 0; i < blk_count; i++) begin
          if ({16'h0, blk_start[i]} == rel) begin
            for (int k = i; k + 1 < blk_count; k++) begin
              blk_start[k] = blk_start[k+1];
              blk_end[k]   = blk_end[k+1];
            end
            blk_count--;
            g.status = STATUS_DONE;
            break;
          end
        end
        if (g.status == STATUS_MISS) n_miss++;
      end
      grant_q = {grant_q, g};
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] granted);
      grant_t g;
      results++;
      if (grant_q.size() == 0) begin
        report_mismatch($sformatf("result status %0d address %08h with none pending",
                                  status, granted));
        return;
      end
      g = grant_q.pop_front();
      if (status !== g.status)
        report_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                  results, status, g.status));
      if (granted !== g.granted)
        report_mismatch($sformatf("result %0d address %08h, predicted %08h",
                                  results, granted, g.granted));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata;   // request_count, free_address
  logic                  s_axis_tuser;   // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_DATA_W-1:0]   m_axis_tdata;   // granted_address
  logic [STATUS_W-1:0]   m_axis_tuser;   // status
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  alloc_scoreboard sb;
  bit              quiet = 1'b0;          // no idling on either side
  bit              hold_off_req = 1'b0;   // asks the receiver for one long hold-off
  int unsigned     cycle_cnt = 0;

  first_fit_block_allocator #(
    .MAX_BLOCKS    (MAX_BLOCKS),
    .ELEMENT_BYTES (ELEMENT_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit, far above the slowest legal run
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // result side: every transfer is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  // receiver: random ready bursts, one long hold-off on request
  initial begin
    int n;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // one request transfer, then maybe an idle burst; valid stays up otherwise
  task automatic send_request(logic op, logic [REQ_W-1:0] req_count, logic [ADDR_W-1:0] addr);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, addr, req_count};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, req_count, addr);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // both registers in back-to-back transfers, only once all results are in
  task automatic set_region(logic [ADDR_W-1:0] base, logic [OFF_W-1:0] bytes);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_REGION_BASE;
    cfg_data_i  <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_REGION_BYTES;
    cfg_data_i  <= {16'($urandom), bytes};   // upper half is ignored
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_region(base, bytes);
  endtask

  // mostly allocations sized to the region and frees of live blocks
  task automatic random_request(int items);
    logic              op;
    logic [REQ_W-1:0]  req_count;
    logic [ADDR_W-1:0] addr;
    int unsigned       r;
    int unsigned       cap;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      op = OP_FREE;
      req_count = REQ_W'($urandom);
      addr = $urandom;
      if (r < 55) begin
        op = OP_ALLOC;
        cap = sb.region_bytes / (4 * ELEMENT_BYTES);
        r = $urandom_range(0, 9);
        if (r == 0) req_count = '0;
        else if (r == 1) req_count = REQ_W'($urandom_range(0, 16383));
        else req_count = REQ_W'($urandom_range(0, cap));
      end else if (r < 90 && sb.blk_count != 0) begin
        addr = sb.region_base + sb.blk_start[$urandom_range(0, sb.blk_count - 1)];
      end else if (r < 95) begin
        // near misses inside the region
        addr = sb.region_base + $urandom_range(0, sb.region_bytes);
      end
      send_request(op, req_count, addr);
    end
  endtask

  initial begin
    sb = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset region: zero count, oversize request that clears and still fails,
    // a hit and a repeated free, free at the top address
    send_request(OP_ALLOC, '0, $urandom);
    send_request(OP_ALLOC, 14'h3fff, $urandom);
    send_request(OP_ALLOC, 14'd50, $urandom);
    send_request(OP_FREE, REQ_W'($urandom), 32'h0);
    send_request(OP_FREE, 14'h3fff, 32'h0);
    send_request(OP_FREE, REQ_W'($urandom), 32'hffff_ffff);

    // one byte region at the top base: zero-length blocks until the table is full
    set_region(32'hffff_ffff, 16'd1);
    repeat (MAX_BLOCKS + 1) send_request(OP_ALLOC, '0, $urandom);
    send_request(OP_FREE, REQ_W'($urandom), 32'hffff_ffff);
    send_request(OP_ALLOC, 14'd1, $urandom);

    // empty region never fits
    set_region(32'h0, 16'd0);
    send_request(OP_ALLOC, 14'd2, $urandom);

    // largest region: the second large request only fits after clearing
    set_region(32'h0, 16'hffff);
    send_request(OP_ALLOC, 14'h3fff, $urandom);
    send_request(OP_ALLOC, 14'h3fff, $urandom);

    // random phases; each region change keeps the table, so blocks can end up
    // past a shrunken region end
    set_region(32'h0, RESET_REGION_BYTES);
    hold_off_req = 1'b1;
    random_request(90);
    set_region(32'hffff_ffff, 16'hffff);
    random_request(90);
    set_region($urandom, OFF_W'($urandom_range(100, 3000)));
    random_request(90);
    set_region($urandom, 16'd1);
    random_request(30);
    set_region($urandom, OFF_W'($urandom_range(64, 1024)));
    quiet = 1'b1;
    random_request(100);
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * MAX_BLOCKS + 8) @(posedge clk_i);

    $display("requests: %0d allocations, %0d frees; %0d results checked",
             sb.n_alloc, sb.n_free, sb.results);
    $display("clear-and-retry %0d, no room %0d, table full %0d, free misses %0d, mismatches %0d",
             sb.n_retry, sb.n_no_room, sb.n_full, sb.n_miss, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
